FILE: design/lse_pkg.sv
// Shared types and constants for the LSB steganography extractor.
// No dependencies; used by every module of the block by scoped names.
`default_nettype none

package lse_pkg;

  // Bits recovered from each carrier byte
  localparam int unsigned PairW = 2;

  // Reset value of the header skip count
  localparam logic [7:0] HeaderReset = 8'd70;

  // Register index decoded from paddr[2]
  localparam logic RegHeader = 1'b0;

  // One accepted carrier item, as held in the input register
  typedef struct packed {
    logic [PairW-1:0] pair;
    logic             frame_start;
  } lse_item_t;

  // One recovered result item
  typedef struct packed {
    logic [7:0] hidden_byte;
    logic       is_name;
    logic       last;
  } lse_result_t;

endpackage

`default_nettype wire

FILE: design/lse_in_stage.sv
// Input register of the LSB steganography extractor.
// Depends on lse_pkg for the item type.
`default_nettype none

module lse_in_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic [7:0]        carrier_byte_i,
  input  wire logic              frame_start_i,
  output logic                   in_ready_o,
  input  wire logic              take_i,
  output logic                   item_valid_o,
  output lse_pkg::lse_item_t     item_o
);

  logic               valid_q, valid_d;
  lse_pkg::lse_item_t item_q;
  logic               accept;

  // Free slot, or the held item leaves this cycle
  assign in_ready_o = !valid_q || take_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Keep only the low bit pair of the carrier byte
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.pair        <= carrier_byte_i[lse_pkg::PairW-1:0];
      item_q.frame_start <= frame_start_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

FILE: design/lse_parser.sv
// Parse state machine and result register of the LSB steganography extractor.
// Depends on lse_pkg for the item and result types.
`default_nettype none

module lse_parser (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [7:0]         header_bytes_i,
  input  wire logic               item_valid_i,
  input  wire lse_pkg::lse_item_t item_i,
  output logic                    take_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output lse_pkg::lse_result_t    result_o
);

  localparam logic [2:0] PhSkip    = 3'd0;
  localparam logic [2:0] PhLen     = 3'd1;
  localparam logic [2:0] PhNlen    = 3'd2;
  localparam logic [2:0] PhName    = 3'd3;
  localparam logic [2:0] PhPayload = 3'd4;
  localparam logic [2:0] PhDone    = 3'd5;

  logic [2:0]  phase_q, phase_d;
  logic [7:0]  fc_q, fc_d;
  logic [1:0]  pidx_q, pidx_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] plen_q, plen_d;
  logic [7:0]  nlen_q, nlen_d;
  logic [31:0] rem_q, rem_d;

  logic                 out_valid_q, out_valid_d;
  lse_pkg::lse_result_t res_q, res_d;
  logic                 fire;
  logic                 skip_hold;
  logic                 enter_pay;

  // Advance the held item when the result register is free or draining
  assign take_o = item_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    phase_d   = phase_q;
    fc_d      = fc_q;
    pidx_d    = pidx_q;
    acc_d     = acc_q;
    plen_d    = plen_q;
    nlen_d    = nlen_q;
    rem_d     = rem_q;
    res_d     = res_q;
    fire      = 1'b0;
    skip_hold = 1'b0;
    enter_pay = 1'b0;

    if (item_i.frame_start) begin
      phase_d = PhSkip;
      fc_d    = '0;
      pidx_d  = '0;
      acc_d   = '0;
      plen_d  = '0;
      nlen_d  = '0;
      rem_d   = '0;
    end

    if (phase_d == PhSkip) begin
      if (fc_d < header_bytes_i) begin
        fc_d      = fc_d + 8'd1;
        skip_hold = 1'b1;
      end else begin
        phase_d = PhLen;
        fc_d    = '0;
        acc_d   = '0;
      end
    end

    if (!skip_hold) begin
      case (phase_d)
        PhLen: begin
          acc_d = {acc_d[29:0], item_i.pair};
          fc_d  = fc_d + 8'd1;
          if (fc_d >= 8'd16) begin
            plen_d  = acc_d;
            acc_d   = '0;
            fc_d    = '0;
            phase_d = PhNlen;
          end
        end
        PhNlen: begin
          acc_d = {24'd0, acc_d[5:0], item_i.pair};
          fc_d  = fc_d + 8'd1;
          if (fc_d >= 8'd4) begin
            nlen_d = acc_d[7:0];
            acc_d  = '0;
            fc_d   = '0;
            pidx_d = '0;
            if (nlen_d != 8'd0) begin
              phase_d = PhName;
            end else begin
              enter_pay = 1'b1;
            end
          end
        end
        PhName, PhPayload: begin
          acc_d = {24'd0, acc_d[5:0], item_i.pair};
          if (pidx_d < 2'd3) begin
            pidx_d = pidx_d + 2'd1;
          end else begin
            fire              = 1'b1;
            res_d.hidden_byte = acc_d[7:0];
            acc_d             = '0;
            pidx_d            = '0;
            if (phase_d == PhName) begin
              res_d.is_name = 1'b1;
              res_d.last    = 1'b0;
              fc_d          = fc_d + 8'd1;
              if (fc_d >= nlen_d) begin
                enter_pay = 1'b1;
              end
            end else begin
              rem_d         = rem_d - 32'd1;
              res_d.is_name = 1'b0;
              res_d.last    = (rem_d == 32'd0);
              if (rem_d == 32'd0) begin
                phase_d = PhDone;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (enter_pay) begin
      fc_d   = '0;
      pidx_d = '0;
      acc_d  = '0;
      rem_d  = plen_d;
      if (plen_d != 32'd0) begin
        phase_d = PhPayload;
      end else begin
        phase_d = PhDone;
      end
    end
  end

  assign out_valid_d = take_o ? fire : (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhSkip;
      fc_q        <= '0;
      pidx_q      <= '0;
      acc_q       <= '0;
      plen_q      <= '0;
      nlen_q      <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take_o) begin
        phase_q <= phase_d;
        fc_q    <= fc_d;
        pidx_q  <= pidx_d;
        acc_q   <= acc_d;
        plen_q  <= plen_d;
        nlen_q  <= nlen_d;
        rem_q   <= rem_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

endmodule

`default_nettype wire

FILE: design/lsb_stego_extractor.sv
// LSB steganography extractor. Carrier bytes enter one item per cycle; the
// block passes over header_bytes leading bytes, then rebuilds a 32-bit payload
// length from 16 bytes and an 8-bit name length from 4 bytes, and finally
// emits one hidden byte per four carrier bytes, name bytes first (is_name
// high), then payload bytes (last high on the final one). Two low bits of
// each carrier byte are used, most significant pair first. frame_start on an
// item restarts the parse with that item as the first header byte; after
// reset the block parses as if a frame had just begun. Bytes after the
// payload are dropped until the next frame_start. Throughput is one carrier
// item per clock while the output is not held: each item passes the input
// register, then a single step of the parse state machine that writes the
// result register. Back pressure on the output holds the result register
// and, through it, the input register; the input side still takes one more
// item while a result waits. header_bytes is an APB register at byte address
// 0 (reset 70); the user must write it only while the block is idle, which
// the block does not enforce. Depends on lse_pkg, lse_in_stage, lse_parser.
`default_nettype none

module lsb_stego_extractor (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // APB configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // Carrier item channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  carrier_byte_i,
  input  wire logic        frame_start_i,
  // Result item channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       hidden_byte_o,
  output logic             is_name_o,
  output logic             last_o
);

  logic [7:0]           header_q, header_d;
  logic                 cfg_wr;
  logic                 item_valid;
  logic                 take;
  lse_pkg::lse_item_t   item;
  lse_pkg::lse_result_t result;

  // Configuration: zero-wait APB, one register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    header_d = header_q;
    if (cfg_wr && (paddr[2] == lse_pkg::RegHeader)) begin
      header_d = pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= lse_pkg::HeaderReset;
    end else begin
      header_q <= header_d;
    end
  end

  // Read back the header count; unmapped addresses read as zero
  assign prdata = (paddr[2] == lse_pkg::RegHeader) ? {24'd0, header_q} : 32'd0;

  // Input register: hold the accepted carrier pair
  lse_in_stage u_in_stage (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .carrier_byte_i (carrier_byte_i),
    .frame_start_i  (frame_start_i),
    .in_ready_o     (in_ready_o),
    .take_i         (take),
    .item_valid_o   (item_valid),
    .item_o         (item)
  );

  // Parse step and result register
  lse_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .header_bytes_i (header_q),
    .item_valid_i   (item_valid),
    .item_i         (item),
    .take_o         (take),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_o       (result)
  );

  assign hidden_byte_o = result.hidden_byte;
  assign is_name_o     = result.is_name;
  assign last_o        = result.last;

  // Ready drops only with a held item that cannot advance
  a_ready_low_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (item_valid && !take))
    else $error("input ready low without a stalled item");

  // A stalled item stays in the input register
  a_item_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid && !take) |=> item_valid)
    else $error("stalled item dropped");

  // Name bytes never carry the last mark
  a_name_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_name_o) |-> !last_o)
    else $error("last mark on a name byte");

  // A header write lands in the register
  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_wr && (paddr[2] == lse_pkg::RegHeader)) |=> (header_q == $past(pwdata[7:0])))
    else $error("header register write lost");

endmodule

`default_nettype wire
